// ===== rtl/core/q12alu_pkg.sv =====
// Package for the Q12.4 fixed-point ALU: opcodes, queue entry layout and
// format constants shared by the front end, queue and execution pipeline.
// No dependencies.
package q12alu_pkg;

    localparam int FRAC_BITS = 4;
    localparam int WORD_W    = 16;
    localparam int DEC_W     = 26;
    localparam int OP_W      = 4;

    localparam int DEC_SCALE  = 10000;
    localparam int DEC_STEP   = DEC_SCALE >> FRAC_BITS;
    localparam int DEC_STEP_W = 10;
    localparam int DEC_MAG_W  = 25;

    localparam logic signed [DEC_W-1:0] DEC_MIN = -26'sd20480000;
    localparam logic signed [DEC_W-1:0] DEC_MAX = 26'sd20479999;

    localparam int RECIP_SHIFT = 35;
    localparam int RECIP_W     = 26;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(DEC_STEP) - 64'd1) / 64'(DEC_STEP);
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_FULL);

    localparam int MUL_W     = 2 * WORD_W;
    localparam int MUL_ROUND = 1 << (FRAC_BITS - 1);

    localparam int DIV_PRE    = FRAC_BITS - 1;
    localparam int NUM_W      = WORD_W + DIV_PRE;
    localparam int DEN_W      = WORD_W - 1;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int SH_W       = DIV_STAGES * DIV_STEP;

    localparam int QUEUE_DEPTH = 4;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_ABS      = 4'd4,
        OP_FLOOR    = 4'd5,
        OP_CEIL     = 4'd6,
        OP_TO_DEC   = 4'd7,
        OP_FROM_DEC = 4'd8,
        OP_NONE     = 4'd15
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic [DEC_MAG_W-1:0]     dec_mag;
        logic                     dec_neg;
        logic [NUM_W-1:0]         div_num;
        logic [DEN_W-1:0]         div_den;
        logic                     div_neg;
        logic                     div_bypass;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/core/q12_4_fixed_point_alu.sv =====
// Q12.4 fixed-point ALU top level: front end, entry queue, execution pipeline.
// Depends on q12alu_pkg, q12alu_front, q12alu_queue and q12alu_exec.
// Path: an accepted beat goes through the queue, the head register, the divider stages and the output register.
// Throughput: one beat per cycle unless the output stalls; the queue absorbs QUEUE_DEPTH beats while m_tready is low.
// Reset: rst_n asynchronous, active low; empties the queue and all pipeline valids.
// The divider advances 4 quotient bits per stage over 5 stages, which sets the latency.
module q12_4_fixed_point_alu #(
    parameter int QUEUE_DEPTH = q12alu_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // operand_a [15:0], operand_b [31:16], decimal_in [57:32], zero [63:58]
    input  logic [q12alu_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type [3:0]
    input  logic [q12alu_pkg::OP_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fixed_result [15:0], decimal_result [41:16], zero [47:42]
    output logic [q12alu_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int WORD_W = q12alu_pkg::WORD_W;
    localparam int DEC_W  = q12alu_pkg::DEC_W;

    q12alu_pkg::entry_t          push_entry, pop_entry;
    q12alu_pkg::q_stat_t         q_stat;
    logic                        push, pop;
    logic signed [WORD_W-1:0]    fixed_result;
    logic signed [DEC_W-1:0]     decimal_result;

    q12alu_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_type   (s_tuser),
        .operand_a  (s_tdata[WORD_W-1:0]),
        .operand_b  (s_tdata[2*WORD_W-1:WORD_W]),
        .decimal_in (s_tdata[2*WORD_W+DEC_W-1:2*WORD_W]),
        .q_stat     (q_stat),
        .push       (push),
        .entry      (push_entry)
    );

    q12alu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_entry),
        .pop   (pop),
        .dout  (pop_entry),
        .stat  (q_stat)
    );

    q12alu_exec u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .entry          (pop_entry),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .fixed_result   (fixed_result),
        .decimal_result (decimal_result)
    );

    assign m_tdata = {{(q12alu_pkg::M_TDATA_W - WORD_W - DEC_W){1'b0}},
                      decimal_result, fixed_result};

endmodule

// ===== rtl/core/q12alu_front.sv =====
// Front end of the Q12.4 ALU: accepts input beats, decodes the opcode and
// prepares operand magnitudes, signs and clamps for the queue.
// Depends on q12alu_pkg.
module q12alu_front (
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [q12alu_pkg::OP_W-1:0]           req_type,
    input  logic signed [q12alu_pkg::WORD_W-1:0]  operand_a,
    input  logic signed [q12alu_pkg::WORD_W-1:0]  operand_b,
    input  logic signed [q12alu_pkg::DEC_W-1:0]   decimal_in,
    input  q12alu_pkg::q_stat_t                   q_stat,
    output logic                                  push,
    output q12alu_pkg::entry_t                    entry
);

    logic signed [q12alu_pkg::DEC_W-1:0]  dec_clamp;
    logic [q12alu_pkg::DEC_W-1:0]         dec_abs;
    logic signed [q12alu_pkg::DEN_W-1:0]  den_s;
    logic [q12alu_pkg::DEN_W-1:0]         den_mag;
    logic [q12alu_pkg::WORD_W-1:0]        a_mag;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        priority if (decimal_in < q12alu_pkg::DEC_MIN)
        begin
            dec_clamp = q12alu_pkg::DEC_MIN;
        end
        else if (decimal_in > q12alu_pkg::DEC_MAX)
        begin
            dec_clamp = q12alu_pkg::DEC_MAX;
        end
        else
        begin
            dec_clamp = decimal_in;
        end
    end

    assign dec_abs = dec_clamp[q12alu_pkg::DEC_W-1] ? (~dec_clamp + 1'b1) : dec_clamp;
    assign den_s   = operand_b[q12alu_pkg::WORD_W-1:1];
    assign den_mag = den_s[q12alu_pkg::DEN_W-1] ? (~den_s + 1'b1) : den_s;
    assign a_mag   = operand_a[q12alu_pkg::WORD_W-1] ? (~operand_a + 1'b1) : operand_a;

    always_comb
    begin
        if (req_type <= q12alu_pkg::OP_FROM_DEC)
        begin
            entry.op = q12alu_pkg::op_t'(req_type);
        end
        else
        begin
            entry.op = q12alu_pkg::OP_NONE;
        end
        entry.a          = operand_a;
        entry.b          = operand_b;
        entry.dec_mag    = dec_abs[q12alu_pkg::DEC_MAG_W-1:0];
        entry.dec_neg    = dec_clamp[q12alu_pkg::DEC_W-1];
        entry.div_num    = {a_mag, {q12alu_pkg::DIV_PRE{1'b0}}};
        entry.div_den    = den_mag;
        entry.div_neg    = operand_a[q12alu_pkg::WORD_W-1] ^ den_s[q12alu_pkg::DEN_W-1];
        entry.div_bypass = (operand_a == '0) || (den_s == '0);
    end

endmodule

// ===== rtl/core/q12alu_queue.sv =====
// Short queue between the ALU front end and the execution pipeline.
// Holds decoded entries so either side can stall on its own.
// Depends on q12alu_pkg.
module q12alu_queue #(
    parameter int DEPTH = q12alu_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  q12alu_pkg::entry_t  din,
    input  logic                pop,
    output q12alu_pkg::entry_t  dout,
    output q12alu_pkg::q_stat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    q12alu_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== rtl/core/q12alu_exec.sv =====
// Execution pipeline of the Q12.4 ALU: multipliers, pipelined radix-2 divider
// and result selection, ending in the output register.
// Depends on q12alu_pkg.
module q12alu_exec (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  q12alu_pkg::q_stat_t                  q_stat,
    input  q12alu_pkg::entry_t                   entry,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic signed [q12alu_pkg::WORD_W-1:0] fixed_result,
    output logic signed [q12alu_pkg::DEC_W-1:0]  decimal_result
);

    localparam int WORD_W = q12alu_pkg::WORD_W;
    localparam int DEC_W  = q12alu_pkg::DEC_W;
    localparam int FB     = q12alu_pkg::FRAC_BITS;
    localparam int DEN_W  = q12alu_pkg::DEN_W;
    localparam int SH_W   = q12alu_pkg::SH_W;
    localparam int NST    = q12alu_pkg::DIV_STAGES;
    localparam int DPW    = WORD_W + q12alu_pkg::DEC_STEP_W + 1;
    localparam int RPW    = q12alu_pkg::DEC_MAG_W + q12alu_pkg::RECIP_W;

    typedef struct packed {
        q12alu_pkg::op_t                     op;
        logic [WORD_W-1:0]                   fixed;
        logic [q12alu_pkg::MUL_W-1:0]        mul_prod;
        logic [DEC_W-1:0]                    dec_prod;
        logic [WORD_W-1:0]                   rec_q;
        logic                                dec_neg;
        logic [q12alu_pkg::NUM_W-1:0]        div_num;
        logic [DEN_W-1:0]                    div_den;
        logic                                div_neg;
        logic                                div_bypass;
    } head_t;

    typedef struct packed {
        logic              use_quot;
        logic              neg;
        logic [WORD_W-1:0] fixed;
        logic [DEC_W-1:0]  decimal;
        logic [DEN_W-1:0]  rem;
        logic [SH_W-1:0]   sh;
        logic [DEN_W-1:0]  den;
    } div_t;

    function automatic div_t div_iter(input div_t s);
        div_t         r;
        logic [DEN_W:0] trial;
        r = s;
        for (int j = 0; j < q12alu_pkg::DIV_STEP; j++)
        begin
            trial = {r.rem, r.sh[SH_W-1]};
            r.sh  = {r.sh[SH_W-2:0], 1'b0};
            if (trial >= {1'b0, r.den})
            begin
                r.rem   = DEN_W'(trial - {1'b0, r.den});
                r.sh[0] = 1'b1;
            end
            else
            begin
                r.rem = trial[DEN_W-1:0];
            end
        end
        return r;
    endfunction

    logic                                adv;
    logic signed [q12alu_pkg::MUL_W-1:0] mul_full;
    logic signed [DPW-1:0]               dec_full;
    logic [RPW-1:0]                      rec_full;
    logic [q12alu_pkg::MUL_W-1:0]        mul_rnd;
    head_t                               head_reg, head_next;
    logic                                head_valid_reg;
    div_t                                body_start;
    div_t                                stage_in   [NST];
    div_t                                body_next  [NST];
    div_t                                body_reg   [NST];
    logic [NST-1:0]                      body_valid_reg;
    logic [WORD_W-1:0]                   quot;
    logic                                out_valid_reg;
    logic [WORD_W-1:0]                   fixed_reg, fixed_next;
    logic [DEC_W-1:0]                    decimal_reg;

    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && !q_stat.empty;

    assign mul_full = $signed(entry.a) * $signed(entry.b);
    assign dec_full = $signed(entry.a)
                    * $signed({1'b0, q12alu_pkg::DEC_STEP_W'(q12alu_pkg::DEC_STEP)});
    assign rec_full = entry.dec_mag * q12alu_pkg::RECIP_MUL;

    always_comb
    begin
        head_next.op         = entry.op;
        head_next.mul_prod   = mul_full;
        head_next.dec_prod   = dec_full[DEC_W-1:0];
        head_next.rec_q      = rec_full[q12alu_pkg::RECIP_SHIFT +: WORD_W];
        head_next.dec_neg    = entry.dec_neg;
        head_next.div_num    = entry.div_num;
        head_next.div_den    = entry.div_den;
        head_next.div_neg    = entry.div_neg;
        head_next.div_bypass = entry.div_bypass;
        unique case (entry.op)
            q12alu_pkg::OP_ADD:   head_next.fixed = entry.a + entry.b;
            q12alu_pkg::OP_SUB:   head_next.fixed = entry.a - entry.b;
            q12alu_pkg::OP_ABS:
                head_next.fixed = entry.a[WORD_W-1] ? (~entry.a + 1'b1) : entry.a;
            q12alu_pkg::OP_FLOOR: head_next.fixed = {entry.a[WORD_W-1:FB], {FB{1'b0}}};
            q12alu_pkg::OP_CEIL:
            begin
                if (entry.a[FB-1:0] == '0)
                begin
                    head_next.fixed = entry.a;
                end
                else
                begin
                    head_next.fixed = {entry.a[WORD_W-1:FB] + 1'b1, {FB{1'b0}}};
                end
            end
            q12alu_pkg::OP_DIV:   head_next.fixed = entry.a;
            default:              head_next.fixed = '0;
        endcase
    end

    assign mul_rnd = head_reg.mul_prod + q12alu_pkg::MUL_W'(q12alu_pkg::MUL_ROUND);

    always_comb
    begin
        body_start.use_quot = (head_reg.op == q12alu_pkg::OP_DIV) && !head_reg.div_bypass;
        body_start.neg      = head_reg.div_neg;
        body_start.rem      = '0;
        body_start.sh       = SH_W'(head_reg.div_num);
        body_start.den      = head_reg.div_den;
        body_start.decimal  = (head_reg.op == q12alu_pkg::OP_TO_DEC) ? head_reg.dec_prod : '0;
        unique case (head_reg.op)
            q12alu_pkg::OP_MUL:      body_start.fixed = mul_rnd[FB +: WORD_W];
            q12alu_pkg::OP_FROM_DEC:
                body_start.fixed = head_reg.dec_neg ? (~head_reg.rec_q + 1'b1) : head_reg.rec_q;
            default:                 body_start.fixed = head_reg.fixed;
        endcase
    end

    always_comb
    begin
        stage_in[0] = body_start;
        for (int k = 1; k < NST; k++)
        begin
            stage_in[k] = body_reg[k-1];
        end
        for (int k = 0; k < NST; k++)
        begin
            body_next[k] = div_iter(stage_in[k]);
        end
    end

    assign quot = body_reg[NST-1].sh[WORD_W-1:0];

    always_comb
    begin
        if (body_reg[NST-1].use_quot)
        begin
            fixed_next = body_reg[NST-1].neg ? (~quot + 1'b1) : quot;
        end
        else
        begin
            fixed_next = body_reg[NST-1].fixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            body_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            head_valid_reg <= pop;
            body_valid_reg <= {body_valid_reg[NST-2:0], head_valid_reg};
            out_valid_reg  <= body_valid_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            head_reg    <= head_next;
            body_reg    <= body_next;
            fixed_reg   <= fixed_next;
            decimal_reg <= body_reg[NST-1].decimal;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign fixed_result   = fixed_reg;
    assign decimal_result = decimal_reg;

endmodule

// ===== rtl/core/q12alu_checker.sv =====
// Port-level checker for the Q12.4 fixed-point ALU, bound to the top level.
// Depends on q12_4_fixed_point_alu.
module q12alu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !s_tvalid |=> s_tready)
        else $error("s_tready dropped without an accepted beat");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[41:16] != 26'd0) |-> (m_tdata[15:0] == 16'd0))
        else $error("decimal and fixed results both nonzero");

    a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:42] == 6'd0)
                     && ($signed(m_tdata[41:16]) >= -26'sd20480000)
                     && ($signed(m_tdata[41:16]) <= 26'sd20479375))
        else $error("decimal result out of range or padding set");

endmodule

bind q12_4_fixed_point_alu q12alu_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/q12_4_fixed_point_alu_tb.sv =====
// Testbench for q12_4_fixed_point_alu: directed corner requests, then random
// requests with random stalls on both stream sides, checked against a predictor.
// Depends on q12alu_pkg and the q12_4_fixed_point_alu RTL.
module q12_4_fixed_point_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    localparam int WORD_W    = q12alu_pkg::WORD_W;
    localparam int DEC_W     = q12alu_pkg::DEC_W;
    localparam int OP_W      = q12alu_pkg::OP_W;
    localparam int FRAC_BITS = q12alu_pkg::FRAC_BITS;
    localparam int MUL_W     = q12alu_pkg::MUL_W;
    localparam int MUL_ROUND = q12alu_pkg::MUL_ROUND;
    localparam int DIV_PRE   = q12alu_pkg::DIV_PRE;
    localparam int DEC_STEP  = q12alu_pkg::DEC_STEP;
    localparam int DEC_SCALE = q12alu_pkg::DEC_SCALE;
    localparam int S_TDATA_W = q12alu_pkg::S_TDATA_W;
    localparam int M_TDATA_W = q12alu_pkg::M_TDATA_W;

    typedef struct packed {
        logic [WORD_W-1:0] fixed_q;
        logic [DEC_W-1:0]  dec_q;
    } alu_result_t;

    class alu_result_tracker;
        alu_result_t pending[$];
        int          errors;
        int          checked;
        int          op_count[16];

        function alu_result_t compute_result(q12alu_pkg::op_t op,
                                             logic signed [WORD_W-1:0] a,
                                             logic signed [WORD_W-1:0] b,
                                             logic signed [DEC_W-1:0] dec);
            logic signed [MUL_W:0] prod;
            int                    num;
            int                    den;
            int                    quo;
            int                    dclamp;
            int unsigned           mag;
            int unsigned           whole;
            int unsigned           rest;
            int unsigned           frac_v;
            alu_result_t           r;
            r = '0;
            case (op)
                q12alu_pkg::OP_ADD: r.fixed_q = a + b;
                q12alu_pkg::OP_SUB: r.fixed_q = a - b;
                q12alu_pkg::OP_MUL:
                begin
                    prod = a * b;
                    prod = prod + MUL_ROUND;
                    r.fixed_q = prod[WORD_W+FRAC_BITS-1:FRAC_BITS];
                end
                q12alu_pkg::OP_DIV:
                begin
                    den = int'(b) >>> 1;
                    if (a == 0 || den == 0)
                    begin
                        r.fixed_q = a;
                    end
                    else
                    begin
                        num = int'(a) * (1 << DIV_PRE);
                        quo = num / den;
                        r.fixed_q = 16'(quo);
                    end
                end
                q12alu_pkg::OP_ABS: r.fixed_q = (a < 0) ? -a : a;
                q12alu_pkg::OP_FLOOR: r.fixed_q = {a[WORD_W-1:FRAC_BITS], 4'd0};
                q12alu_pkg::OP_CEIL:
                begin
                    if (a[FRAC_BITS-1:0] == 4'd0)
                        r.fixed_q = a;
                    else
                        r.fixed_q = {a[WORD_W-1:FRAC_BITS], 4'd0} + (16'd1 << FRAC_BITS);
                end
                q12alu_pkg::OP_TO_DEC: r.dec_q = 26'(int'(a) * DEC_STEP);
                q12alu_pkg::OP_FROM_DEC:
                begin
                    dclamp = dec;
                    if (dclamp < q12alu_pkg::DEC_MIN)
                        dclamp = q12alu_pkg::DEC_MIN;
                    if (dclamp > q12alu_pkg::DEC_MAX)
                        dclamp = q12alu_pkg::DEC_MAX;
                    mag = (dclamp < 0) ? -dclamp : dclamp;
                    whole = mag / DEC_SCALE;
                    rest = mag % DEC_SCALE;
                    frac_v = (whole << FRAC_BITS) + rest / DEC_STEP;
                    r.fixed_q = 16'((dclamp < 0) ? -frac_v : frac_v);
                end
                default: ;
            endcase
            return r;
        endfunction

        function void log_request(q12alu_pkg::op_t op, logic signed [WORD_W-1:0] a,
                                  logic signed [WORD_W-1:0] b,
                                  logic signed [DEC_W-1:0] dec);
            pending.push_back(compute_result(op, a, b, dec));
            op_count[op]++;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            alu_result_t exp_r;
            alu_result_t got;
            got.fixed_q = beat[WORD_W-1:0];
            got.dec_q = beat[WORD_W+DEC_W-1:WORD_W];
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat %0d: fixed %h decimal %h",
                             checked, got.fixed_q, got.dec_q);
                return;
            end
            exp_r = pending.pop_front();
            if (got.fixed_q !== exp_r.fixed_q || got.dec_q !== exp_r.dec_q)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch on result %0d: fixed exp %h got %h, decimal exp %h got %h",
                             checked, exp_r.fixed_q, got.fixed_q, exp_r.dec_q, got.dec_q);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    alu_result_tracker tracker = new();
    int                cycle_count;
    int                sent;
    int                rx_stall;
    logic              hold_rx;
    bit                tx_calm;

    q12_4_fixed_point_alu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, quiet stretches, and the long hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
        if (hold_rx)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else if ((cycle_count / 500) % 4 != 3 && $urandom_range(0, 99) < 30)
        begin
            rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        hold_rx <= 1'b0;
        while (sent < 300)
            @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic send_request(q12alu_pkg::op_t op, logic signed [WORD_W-1:0] a,
                                logic signed [WORD_W-1:0] b,
                                logic signed [DEC_W-1:0] dec);
        s_tuser <= op;
        s_tdata <= {6'd0, dec, b, a};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.log_request(op, a, b, dec);
        sent++;
    endtask

    task automatic sender_gap();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_calm || pick < 55)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [WORD_W-1:0] pick_operand();
        logic signed [WORD_W-1:0] v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 9))
                    0: v = 16'sh0000;
                    1: v = 16'sh0001;
                    2: v = -16'sh0001;
                    3: v = 16'sh0010;
                    4: v = -16'sh0010;
                    5: v = 16'sh7FFF;
                    6: v = 16'sh8000;
                    7: v = 16'sh0008;
                    8: v = -16'sh0008;
                    default: v = 16'sh000F;
                endcase
            end
            1: v = 16'(int'($urandom_range(0, 127)) - 64);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic signed [DEC_W-1:0] pick_decimal();
        logic signed [DEC_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 26'($urandom);
            1: v = $urandom_range(0, 1) ? q12alu_pkg::DEC_MIN : q12alu_pkg::DEC_MAX;
            2: v = 26'((int'($urandom_range(0, 65535)) - 32768) * DEC_STEP);
            default: v = 26'(int'($urandom_range(0, 40959999)) - 20480000);
        endcase
        return v;
    endfunction

    initial
    begin
        q12alu_pkg::op_t          op;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        int                       min_hits;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= q12alu_pkg::OP_ADD;
        tx_calm = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(q12alu_pkg::OP_ADD, 16'sh7FFF, 16'sh0001, 26'sd0);
        send_request(q12alu_pkg::OP_SUB, 16'sh8000, 16'sh0001, 26'sd0);
        send_request(q12alu_pkg::OP_MUL, 16'sh7FFF, 16'sh7FFF, 26'sd0);
        send_request(q12alu_pkg::OP_MUL, 16'sh8000, 16'sh8000, 26'sd0);
        send_request(q12alu_pkg::OP_MUL, 16'sh0008, 16'sh0001, 26'sd0);
        send_request(q12alu_pkg::OP_MUL, -16'sh0009, 16'sh0001, 26'sd0);
        send_request(q12alu_pkg::OP_DIV, 16'sh0000, 16'sh0005, 26'sd0);
        send_request(q12alu_pkg::OP_DIV, 16'sh1234, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_DIV, -16'sh1234, 16'sh0001, 26'sd0);
        send_request(q12alu_pkg::OP_DIV, 16'sh8000, -16'sh0001, 26'sd0);
        send_request(q12alu_pkg::OP_DIV, 16'sh0010, 16'sh0020, 26'sd0);
        send_request(q12alu_pkg::OP_ABS, 16'sh8000, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_ABS, -16'sh0005, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_FLOOR, -16'sh0011, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_CEIL, 16'sh7FF1, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_CEIL, -16'sh0011, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_CEIL, 16'sh0020, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_TO_DEC, 16'sh8000, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_TO_DEC, 16'sh7FFF, 16'sh0000, 26'sd0);
        send_request(q12alu_pkg::OP_FROM_DEC, 16'sh0000, 16'sh0000, q12alu_pkg::DEC_MIN);
        send_request(q12alu_pkg::OP_FROM_DEC, 16'sh0000, 16'sh0000, q12alu_pkg::DEC_MAX);
        send_request(q12alu_pkg::OP_FROM_DEC, 16'sh0000, 16'sh0000, 26'sh1FFFFFF);
        send_request(q12alu_pkg::OP_FROM_DEC, 16'sh0000, 16'sh0000, 26'sh2000000);
        send_request(q12alu_pkg::OP_FROM_DEC, 16'sh0000, 16'sh0000, -26'sd9375);
        send_request(q12alu_pkg::OP_NONE, 16'sh7FFF, 16'sh7FFF, 26'sh1FFFFFF);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            tx_calm = ((i / 150) % 3 == 2);
            if ($urandom_range(0, 49) == 0)
                op = q12alu_pkg::op_t'($urandom_range(q12alu_pkg::OP_FROM_DEC + 1,
                                                      q12alu_pkg::OP_NONE));
            else
                op = q12alu_pkg::op_t'($urandom_range(q12alu_pkg::OP_ADD,
                                                      q12alu_pkg::OP_FROM_DEC));
            a = pick_operand();
            b = pick_operand();
            if (op == q12alu_pkg::OP_DIV && $urandom_range(0, 3) == 0)
                b = 16'(int'($urandom_range(0, 6)) - 3);
            send_request(op, a, b, pick_decimal());
            sender_gap();
        end
        s_tvalid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        min_hits = tracker.op_count[q12alu_pkg::OP_ADD];
        for (int k = q12alu_pkg::OP_ADD; k <= q12alu_pkg::OP_FROM_DEC; k++)
            if (tracker.op_count[k] < min_hits)
                min_hits = tracker.op_count[k];
        $display("%0d requests sent, %0d results checked, %0d errors", sent, tracker.checked,
                 tracker.errors);
        $display("every opcode add..from_dec issued at least %0d times, with random stalls",
                 min_hits);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
